// ===== design/column_vertical_velocity_integrator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Column vertical velocity integrator - assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef COLUMN_VERTICAL_VELOCITY_INTEGRATOR_UNIT_ASSERT_SVH
`define COLUMN_VERTICAL_VELOCITY_INTEGRATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define CVVI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CVVI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cvvi_pkg.sv =====
// ----------------------------------------------------------------------------
// Column vertical velocity integrator - package
// Shared widths, register map, configuration and command types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cvvi_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int SCALE_WIDTH = 32;
  localparam int GAP_WIDTH   = 32;
  localparam int FLAG_WIDTH  = 5;
  localparam int PDATA_WIDTH = 32;
  localparam int PADDR_WIDTH = 4;
  localparam int REG_IDX_WIDTH = 2;

  localparam logic [DATA_WIDTH-1:0] W_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] W_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam logic [REG_IDX_WIDTH-1:0] REG_UPSTREAM_MODE = 2'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_BASAL_MELT    = 2'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_INV_DX        = 2'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_INV_DY        = 2'd3;

  typedef struct packed {
    logic                   upstream_mode;
    logic                   include_basal_melt;
    logic [SCALE_WIDTH-1:0] inv_dx;
    logic [SCALE_WIDTH-1:0] inv_dy;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] u_west;
    logic signed [DATA_WIDTH-1:0] u_center;
    logic signed [DATA_WIDTH-1:0] u_east;
    logic signed [DATA_WIDTH-1:0] v_south;
    logic signed [DATA_WIDTH-1:0] v_center;
    logic signed [DATA_WIDTH-1:0] v_north;
    logic [GAP_WIDTH-1:0]         level_gap;
    logic                         base_level;
    logic [FLAG_WIDTH-1:0]        icy_flags;
    logic signed [DATA_WIDTH-1:0] basal_melt;
  } level_t;

  typedef enum logic [1:0] {
    MSEL_X   = 2'd0,
    MSEL_Y   = 2'd1,
    MSEL_GAP = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     dx_en;
    logic     div_en;
    logic     w_en;
  } cmd_t;

endpackage

// ===== design/cvvi_if.sv =====
// ----------------------------------------------------------------------------
// Column vertical velocity integrator - channel interfaces
// Level request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cvvi_level_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cvvi_pkg::DATA_WIDTH-1:0] u_west;
  logic signed [cvvi_pkg::DATA_WIDTH-1:0] u_center;
  logic signed [cvvi_pkg::DATA_WIDTH-1:0] u_east;
  logic signed [cvvi_pkg::DATA_WIDTH-1:0] v_south;
  logic signed [cvvi_pkg::DATA_WIDTH-1:0] v_center;
  logic signed [cvvi_pkg::DATA_WIDTH-1:0] v_north;
  logic [cvvi_pkg::GAP_WIDTH-1:0]         level_gap;
  logic                                   base_level;
  logic [cvvi_pkg::FLAG_WIDTH-1:0]        icy_flags;
  logic signed [cvvi_pkg::DATA_WIDTH-1:0] basal_melt;

  modport source (
    output valid, u_west, u_center, u_east, v_south, v_center, v_north,
           level_gap, base_level, icy_flags, basal_melt,
    input  ready
  );
  modport sink (
    input  valid, u_west, u_center, u_east, v_south, v_center, v_north,
           level_gap, base_level, icy_flags, basal_melt,
    output ready
  );
endinterface

interface cvvi_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cvvi_pkg::DATA_WIDTH-1:0] w_out;

  modport source (output valid, w_out, input ready);
  modport sink (input valid, w_out, output ready);
endinterface

// ===== design/cvvi_regs.sv =====
// ----------------------------------------------------------------------------
// Column vertical velocity integrator - configuration registers
// APB-style register file: mode bits and reciprocal grid spacings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvvi_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cvvi_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [cvvi_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [cvvi_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                             pready,
  output cvvi_pkg::cfg_t                   cfg
);

  logic                                    wr;
  logic [cvvi_pkg::REG_IDX_WIDTH-1:0]      idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[cvvi_pkg::PADDR_WIDTH-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        cvvi_pkg::REG_UPSTREAM_MODE: cfg.upstream_mode      <= pwdata[0];
        cvvi_pkg::REG_BASAL_MELT:    cfg.include_basal_melt <= pwdata[0];
        cvvi_pkg::REG_INV_DX:        cfg.inv_dx <= pwdata[cvvi_pkg::SCALE_WIDTH-1:0];
        cvvi_pkg::REG_INV_DY:        cfg.inv_dy <= pwdata[cvvi_pkg::SCALE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      cvvi_pkg::REG_UPSTREAM_MODE:
        prdata = cvvi_pkg::PDATA_WIDTH'(cfg.upstream_mode);
      cvvi_pkg::REG_BASAL_MELT:
        prdata = cvvi_pkg::PDATA_WIDTH'(cfg.include_basal_melt);
      cvvi_pkg::REG_INV_DX: prdata = cvvi_pkg::PDATA_WIDTH'(cfg.inv_dx);
      cvvi_pkg::REG_INV_DY: prdata = cvvi_pkg::PDATA_WIDTH'(cfg.inv_dy);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== design/cvvi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Column vertical velocity integrator - controller
// Sequences one level through the shared multiplier and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvvi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           level_valid,
  output logic           level_ready,
  output logic           result_valid,
  input  logic           result_ready,
  output cvvi_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MULX = 6'b000010,
    ST_MULY = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_MULG = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = cvvi_pkg::MSEL_X;
    level_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        level_ready = 1'b1;
        if (level_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MULX;
        end
      end
      ST_MULX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cvvi_pkg::MSEL_X;
        state_next  = ST_MULY;
      end
      ST_MULY: begin
        cmd.dx_en   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cvvi_pkg::MSEL_Y;
        state_next  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_next = ST_MULG;
      end
      ST_MULG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cvvi_pkg::MSEL_GAP;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register frees up
        if (!result_valid || result_ready) begin
          cmd.w_en   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.w_en) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/cvvi_dp.sv =====
// ----------------------------------------------------------------------------
// Column vertical velocity integrator - datapath
// Side weights, shared 33x32 multiplier, divergence and trapezoid update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvvi_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cvvi_pkg::cmd_t                         cmd,
  input  cvvi_pkg::cfg_t                         cfg,
  input  cvvi_pkg::level_t                       lvl,
  output logic signed [cvvi_pkg::DATA_WIDTH-1:0] w_out
);

  localparam int DW     = cvvi_pkg::DATA_WIDTH;
  localparam int MAG_W  = DW + 1;
  localparam int PROD_W = MAG_W + cvvi_pkg::SCALE_WIDTH;

  typedef enum logic [1:0] {
    SH_FULL = 2'd0,
    SH_HALF = 2'd1,
    SH_GAP  = 2'd2
  } shift_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    shift_t           sh;
  } mul_op_t;

  function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a,
                                            input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? cvvi_pkg::W_MIN : cvvi_pkg::W_MAX;
    end
    return s[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] sat_sub(input logic [DW-1:0] a,
                                            input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? cvvi_pkg::W_MIN : cvvi_pkg::W_MAX;
    end
    return s[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] scale_sat(input logic [PROD_W-1:0] p,
                                              input logic neg, input shift_t sh);
    logic [PROD_W-1:0] r;
    logic [PROD_W-1:0] lim;
    logic [DW-1:0]     m;
    case (sh)
      SH_HALF: r = p >> (cvvi_pkg::SCALE_WIDTH + 1);
      SH_GAP:  r = p >> (cvvi_pkg::GAP_WIDTH / 2 + 1);
      default: r = p >> cvvi_pkg::SCALE_WIDTH;
    endcase
    lim = {{(PROD_W-DW){1'b0}}, cvvi_pkg::W_MAX} + PROD_W'(neg);
    if (r > lim) begin
      r = lim;
    end
    m = r[DW-1:0];
    return neg ? (~m + 1'b1) : m;
  endfunction

  function automatic mul_op_t deriv_op(input logic [DW-1:0] lo, input logic [DW-1:0] c,
                                       input logic [DW-1:0] hi, input logic hi_side,
                                       input logic lo_side);
    logic [DW:0] d;
    mul_op_t     op;
    d     = '0;
    op.sh = SH_FULL;
    if (hi_side && lo_side) begin
      d     = {hi[DW-1], hi} - {lo[DW-1], lo};
      op.sh = SH_HALF;
    end else if (hi_side) begin
      d = {hi[DW-1], hi} - {c[DW-1], c};
    end else if (lo_side) begin
      d = {c[DW-1], c} - {lo[DW-1], lo};
    end
    op.neg = d[DW];
    op.mag = d[DW] ? (~d + 1'b1) : d;
    return op;
  endfunction

  // bit0 high side, bit1 low side
  function automatic logic [1:0] pick_pair(input logic [DW-1:0] lo, input logic [DW-1:0] c,
                                           input logic [DW-1:0] hi);
    logic [DW:0] a;
    logic [DW:0] b;
    logic        a_pos;
    a     = {lo[DW-1], lo} + {c[DW-1], c};
    b     = {c[DW-1], c} + {hi[DW-1], hi};
    a_pos = !a[DW] && (a != '0);
    if (a_pos && !b[DW]) begin
      return 2'b10;
    end
    if (!a_pos && b[DW]) begin
      return 2'b01;
    end
    return 2'b11;
  endfunction

  cvvi_pkg::level_t              lq;
  logic [3:0]                    side_weights;
  logic [cvvi_pkg::SCALE_WIDTH-1:0] x_scale;
  logic [cvvi_pkg::SCALE_WIDTH-1:0] y_scale;
  logic [DW-1:0]                 prev_divergence;
  logic [DW-1:0]                 prev_w;
  logic [DW-1:0]                 dx;
  logic [DW-1:0]                 divergence;
  logic [PROD_W-1:0]             prod;
  logic                          prod_neg;
  shift_t                        prod_sh;

  logic [1:0]                    xw;
  logic [1:0]                    yw;
  logic                          ctr;
  mul_op_t                       op;
  logic [cvvi_pkg::SCALE_WIDTH-1:0] mul_b;
  logic [DW-1:0]                 s_sum;
  logic [DW:0]                   s_ext;
  logic [DW-1:0]                 prod_val;
  logic [DW-1:0]                 melt_w;
  logic [DW-1:0]                 w_next;

  always_comb begin
    ctr = lvl.icy_flags[0];
    xw  = cfg.upstream_mode ? pick_pair(lvl.u_west, lvl.u_center, lvl.u_east) : 2'b11;
    yw  = cfg.upstream_mode ? pick_pair(lvl.v_south, lvl.v_center, lvl.v_north) : 2'b11;
    // drop sides across an ice margin
    xw[0] = xw[0] && (lvl.icy_flags[1] == ctr);
    xw[1] = xw[1] && (lvl.icy_flags[2] == ctr);
    yw[0] = yw[0] && (lvl.icy_flags[3] == ctr);
    yw[1] = yw[1] && (lvl.icy_flags[4] == ctr);
  end

  assign s_sum = sat_add(divergence, prev_divergence);
  assign s_ext = {s_sum[DW-1], s_sum};

  always_comb begin
    case (cmd.mul_sel)
      cvvi_pkg::MSEL_Y: begin
        op    = deriv_op(lq.v_south, lq.v_center, lq.v_north,
                         side_weights[2], side_weights[3]);
        mul_b = y_scale;
      end
      cvvi_pkg::MSEL_GAP: begin
        op.neg = s_sum[DW-1];
        op.mag = s_sum[DW-1] ? (~s_ext + 1'b1) : s_ext;
        op.sh  = SH_GAP;
        mul_b  = lq.level_gap;
      end
      default: begin
        op    = deriv_op(lq.u_west, lq.u_center, lq.u_east,
                         side_weights[0], side_weights[1]);
        mul_b = x_scale;
      end
    endcase
  end

  assign prod_val = scale_sat(prod, prod_neg, prod_sh);
  assign melt_w   = (lq.basal_melt == cvvi_pkg::W_MIN) ? cvvi_pkg::W_MAX
                                                       : (~lq.basal_melt + 1'b1);

  always_comb begin
    if (lq.base_level) begin
      w_next = cfg.include_basal_melt ? melt_w : '0;
    end else begin
      w_next = sat_sub(prev_w, prod_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_weights    <= '0;
      x_scale         <= '0;
      y_scale         <= '0;
      prev_divergence <= '0;
      prev_w          <= '0;
    end else begin
      if (cmd.load && lvl.base_level) begin
        side_weights <= {yw, xw};
        x_scale      <= cfg.inv_dx;
        y_scale      <= cfg.inv_dy;
      end
      if (cmd.w_en) begin
        prev_divergence <= divergence;
        prev_w          <= w_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lq <= lvl;
    end
    if (cmd.mul_en) begin
      prod     <= PROD_W'(op.mag) * PROD_W'(mul_b);
      prod_neg <= op.neg;
      prod_sh  <= op.sh;
    end
    if (cmd.dx_en) begin
      dx <= prod_val;
    end
    if (cmd.div_en) begin
      divergence <= sat_add(dx, prod_val);
    end
    if (cmd.w_en) begin
      w_out <= w_next;
    end
  end

endmodule

// ===== design/column_vertical_velocity_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// Column vertical velocity integrator
// Integrates horizontal divergence up an ice column, one level per request.
// ----------------------------------------------------------------------------
// Send the levels of a column bottom first, the base level flagged.
// A taken level steps through MULX, MULY, DIV, MULG and DONE, where w_out
// and its valid are registered; a new level is taken only back in IDLE,
// as the single 33x32 multiplier is used in turn for the x derivative,
// the y derivative and the trapezoid step. A finished result waits in the
// output register while the next level is taken in; if it is still not
// taken when the next one is done, the block holds. Write the
// configuration registers only while no level is in flight.
`timescale 1ns / 1ps

module column_vertical_velocity_integrator_unit (
  input  logic                             clk,
  input  logic                             rst,
  cvvi_level_if.sink                       level,
  cvvi_result_if.source                    result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cvvi_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [cvvi_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic [cvvi_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                             pready
);

  cvvi_pkg::cfg_t   cfg;
  cvvi_pkg::cmd_t   cmd;
  cvvi_pkg::level_t lvl;

  assign lvl.u_west     = level.u_west;
  assign lvl.u_center   = level.u_center;
  assign lvl.u_east     = level.u_east;
  assign lvl.v_south    = level.v_south;
  assign lvl.v_center   = level.v_center;
  assign lvl.v_north    = level.v_north;
  assign lvl.level_gap  = level.level_gap;
  assign lvl.base_level = level.base_level;
  assign lvl.icy_flags  = level.icy_flags;
  assign lvl.basal_melt = level.basal_melt;

  cvvi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cvvi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .level_valid  (level.valid),
    .level_ready  (level.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd)
  );

  cvvi_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .cfg   (cfg),
    .lvl   (lvl),
    .w_out (result.w_out)
  );

endmodule

// ===== design/cvvi_checker.sv =====
// ----------------------------------------------------------------------------
// Column vertical velocity integrator - port checker
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "column_vertical_velocity_integrator_unit_assert.svh"

module cvvi_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             level_valid,
  input logic                             level_ready,
  input logic                             result_valid,
  input logic                             result_ready,
  input logic [cvvi_pkg::DATA_WIDTH-1:0]  w_out,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [cvvi_pkg::PADDR_WIDTH-1:0] paddr,
  input logic [cvvi_pkg::PDATA_WIDTH-1:0] pwdata,
  input logic [cvvi_pkg::PDATA_WIDTH-1:0] prdata,
  input logic                             pready
);

  logic [1:0] pending;
  logic       lvl_acc;
  logic       res_acc;
  logic       cfg_wr;

  assign lvl_acc = level_valid && level_ready;
  assign res_acc = result_valid && result_ready;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (lvl_acc && !res_acc) begin
      pending <= pending + 2'd1;
    end else if (!lvl_acc && res_acc) begin
      pending <= pending - 2'd1;
    end
  end

  `CVVI_ASSERT_NXT(a_result_hold, result_valid && !result_ready,
    result_valid && $stable(w_out), "stalled result changed")

  `CVVI_ASSERT_IMP(a_no_invented, result_valid, pending != 2'd0,
    "result with no level outstanding")

  `CVVI_ASSERT_IMP(a_depth, 1'b1, pending != 2'd3,
    "more than two levels outstanding")

  `CVVI_ASSERT_IMP(a_inv_dx_readback,
    (cfg_wr && paddr[3:2] == cvvi_pkg::REG_INV_DX) ##1
    (psel && !pwrite && paddr[3:2] == cvvi_pkg::REG_INV_DX),
    prdata == $past(pwdata), "inv_dx readback mismatch")

endmodule

bind column_vertical_velocity_integrator_unit cvvi_checker u_cvvi_checker (
  .clk          (clk),
  .rst          (rst),
  .level_valid  (level.valid),
  .level_ready  (level.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .w_out        (result.w_out),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata),
  .pready       (pready)
);

// ===== bench/column_w_checker.sv =====
// ----------------------------------------------------------------------------
// Column vertical velocity integrator - result checker
// Watches the level and result channels and the register port. Mirrors the
// register writes, predicts w_out for every level request taken by the
// block, and compares each result taken from the block with the oldest
// prediction. Hands the failure count and the number of open predictions
// to the bench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module column_w_checker (
  input  logic                             clk,
  input  logic                             rst,
  cvvi_level_if                            lvl,
  cvvi_result_if                           res,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [cvvi_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [cvvi_pkg::PDATA_WIDTH-1:0] pwdata,
  output int                               failures,
  output int                               pending
);

  localparam longint W_HI = (longint'(1) << (cvvi_pkg::DATA_WIDTH - 1)) - 1;
  localparam longint W_LO = -W_HI - 1;

  cvvi_pkg::cfg_t                         regs;
  logic [3:0]                             side_w;
  logic [cvvi_pkg::SCALE_WIDTH-1:0]       x_scale_q;
  logic [cvvi_pkg::SCALE_WIDTH-1:0]       y_scale_q;
  longint                                 prev_div;
  longint                                 prev_w;
  logic signed [cvvi_pkg::DATA_WIDTH-1:0] w_expected [$];
  int                                     fail_count;

  function automatic longint clamp_w(input longint x);
    if (x > W_HI) return W_HI;
    if (x < W_LO) return W_LO;
    return x;
  endfunction

  function automatic longint scaled_product(input bit neg, input longint unsigned mag,
                                            input logic [31:0] k, input int unsigned sh);
    logic [127:0]    prod;
    longint unsigned cap;
    prod = 128'(mag) * 128'(k);
    prod = prod >> sh;
    cap  = neg ? longint'(W_HI) + 1 : longint'(W_HI);
    if (prod > 128'(cap)) prod = 128'(cap);
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint slope(input longint lo, input longint c, input longint hi,
                                   input bit hi_on, input bit lo_on,
                                   input logic [cvvi_pkg::SCALE_WIDTH-1:0] k);
    longint      d;
    int unsigned sh;
    if (hi_on && lo_on) begin
      d  = hi - lo;
      sh = 33;
    end else if (hi_on) begin
      d  = hi - c;
      sh = 32;
    end else if (lo_on) begin
      d  = c - lo;
      sh = 32;
    end else begin
      return 0;
    end
    return scaled_product(d < 0, (d < 0) ? -d : d, k, sh);
  endfunction

  // bit0 high side (east/north), bit1 low side (west/south)
  function automatic logic [1:0] side_pick(input longint lo, input longint c,
                                           input longint hi);
    longint a;
    longint b;
    a = lo + c;
    b = c + hi;
    if (a > 0 && b >= 0) return 2'b10;
    if (a <= 0 && b < 0) return 2'b01;
    return 2'b11;
  endfunction

  task automatic predict_w(input cvvi_pkg::level_t it);
    logic [1:0] xw;
    logic [1:0] yw;
    logic       c;
    longint     uw, uc, ue, vs, vc, vn, melt;
    longint     div, s, w;
    uw   = longint'($signed(it.u_west));
    uc   = longint'($signed(it.u_center));
    ue   = longint'($signed(it.u_east));
    vs   = longint'($signed(it.v_south));
    vc   = longint'($signed(it.v_center));
    vn   = longint'($signed(it.v_north));
    melt = longint'($signed(it.basal_melt));
    if (it.base_level) begin
      xw = 2'b11;
      yw = 2'b11;
      if (regs.upstream_mode) begin
        xw = side_pick(uw, uc, ue);
        yw = side_pick(vs, vc, vn);
      end
      c = it.icy_flags[0];
      if (it.icy_flags[1] != c) xw[0] = 1'b0;
      if (it.icy_flags[2] != c) xw[1] = 1'b0;
      if (it.icy_flags[3] != c) yw[0] = 1'b0;
      if (it.icy_flags[4] != c) yw[1] = 1'b0;
      side_w    = {yw, xw};
      x_scale_q = regs.inv_dx;
      y_scale_q = regs.inv_dy;
    end
    div = clamp_w(slope(uw, uc, ue, side_w[0], side_w[1], x_scale_q)
                + slope(vs, vc, vn, side_w[2], side_w[3], y_scale_q));
    if (it.base_level) begin
      w = regs.include_basal_melt ? clamp_w(-melt) : 0;
    end else begin
      s = clamp_w(div + prev_div);
      w = clamp_w(prev_w - scaled_product(s < 0, (s < 0) ? -s : s, it.level_gap, 17));
    end
    prev_div = div;
    prev_w   = w;
    w_expected.push_back(cvvi_pkg::DATA_WIDTH'(w));
  endtask

  always @(posedge clk) begin : watch
    cvvi_pkg::level_t                       seen;
    logic signed [cvvi_pkg::DATA_WIDTH-1:0] want;
    if (rst) begin
      regs       = '0;
      side_w     = '0;
      x_scale_q  = '0;
      y_scale_q  = '0;
      prev_div   = 0;
      prev_w     = 0;
      fail_count = 0;
      w_expected.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[cvvi_pkg::REG_IDX_WIDTH+1:2])
          cvvi_pkg::REG_UPSTREAM_MODE: regs.upstream_mode      = pwdata[0];
          cvvi_pkg::REG_BASAL_MELT:    regs.include_basal_melt = pwdata[0];
          cvvi_pkg::REG_INV_DX: regs.inv_dx = pwdata[cvvi_pkg::SCALE_WIDTH-1:0];
          cvvi_pkg::REG_INV_DY: regs.inv_dy = pwdata[cvvi_pkg::SCALE_WIDTH-1:0];
          default: ;
        endcase
      end
      if (lvl.valid && lvl.ready) begin
        seen.u_west     = lvl.u_west;
        seen.u_center   = lvl.u_center;
        seen.u_east     = lvl.u_east;
        seen.v_south    = lvl.v_south;
        seen.v_center   = lvl.v_center;
        seen.v_north    = lvl.v_north;
        seen.level_gap  = lvl.level_gap;
        seen.base_level = lvl.base_level;
        seen.icy_flags  = lvl.icy_flags;
        seen.basal_melt = lvl.basal_melt;
        predict_w(seen);
      end
      if (res.valid && res.ready) begin
        if (w_expected.size() == 0) begin
          $error("w_out: expected none, got %0d", res.w_out);
          fail_count++;
        end else begin
          want = w_expected.pop_front();
          if (want !== res.w_out) begin
            $error("w_out: expected %0d, got %0d", want, res.w_out);
            fail_count++;
          end
        end
      end
    end
    failures <= fail_count;
    pending  <= w_expected.size();
  end

endmodule

// ===== bench/column_vertical_velocity_integrator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Column vertical velocity integrator - testbench top
// Drives level requests column by column with random gaps, stalls the result
// side at random, and rewrites the registers between phases while the block
// is idle. A directed opening covers the value extremes, every margin and
// upstream case and the melt saturation; random columns and stray levels
// follow. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module column_vertical_velocity_integrator_unit_tb;

  localparam int RANDOM_LEVELS = 1500;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic [cvvi_pkg::DATA_WIDTH-1:0] V_MAX = cvvi_pkg::W_MAX;
  localparam logic [cvvi_pkg::DATA_WIDTH-1:0] V_MIN = cvvi_pkg::W_MIN;

  logic                             clk;
  logic                             rst;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [cvvi_pkg::PADDR_WIDTH-1:0] paddr;
  logic [cvvi_pkg::PDATA_WIDTH-1:0] pwdata;
  logic [cvvi_pkg::PDATA_WIDTH-1:0] prdata;
  logic                             pready;
  int                               failures;
  int                               pending;
  int                               cycle_count;

  cvvi_level_if  lvl ();
  cvvi_result_if res ();

  column_vertical_velocity_integrator_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .level   (lvl),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  column_w_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .lvl      (lvl),
    .res      (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .failures (failures),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned accept_len();
    if ($urandom_range(0, 7) == 0) return $urandom_range(100, 300);
    return $urandom_range(1, 8);
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return V_MIN;
          1: return V_MAX;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          default: return 32'h1;
        endcase
      end
      1: return 32'($urandom_range(0, 6)) - 32'd3;
      2, 3: return $urandom;
      default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_gap();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      1, 2: return $urandom;
      default: return $urandom_range(0, 32'h0002_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      1: return $urandom;
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic logic [4:0] rand_icy();
    case ($urandom_range(0, 3))
      0: return 5'h1F;
      1: return 5'h00;
      default: return 5'($urandom);
    endcase
  endfunction

  function automatic cvvi_pkg::level_t make_level(
    input logic [31:0] uw, input logic [31:0] uc, input logic [31:0] ue,
    input logic [31:0] vs, input logic [31:0] vc, input logic [31:0] vn,
    input logic [31:0] gap, input logic base, input logic [4:0] icy,
    input logic [31:0] melt);
    cvvi_pkg::level_t it;
    it.u_west     = uw;
    it.u_center   = uc;
    it.u_east     = ue;
    it.v_south    = vs;
    it.v_center   = vc;
    it.v_north    = vn;
    it.level_gap  = gap;
    it.base_level = base;
    it.icy_flags  = icy;
    it.basal_melt = melt;
    return it;
  endfunction

  // valid stays high across back-to-back requests
  task automatic send_level(input cvvi_pkg::level_t it, input int unsigned gap);
    if (gap > 0) begin
      lvl.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    lvl.valid      <= 1'b1;
    lvl.u_west     <= it.u_west;
    lvl.u_center   <= it.u_center;
    lvl.u_east     <= it.u_east;
    lvl.v_south    <= it.v_south;
    lvl.v_center   <= it.v_center;
    lvl.v_north    <= it.v_north;
    lvl.level_gap  <= it.level_gap;
    lvl.base_level <= it.base_level;
    lvl.icy_flags  <= it.icy_flags;
    lvl.basal_melt <= it.basal_melt;
    @(posedge clk);
    while (!lvl.ready) @(posedge clk);
  endtask

  task automatic drain();
    lvl.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cvvi_pkg::REG_IDX_WIDTH-1:0] idx,
                           input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cvvi_pkg::PADDR_WIDTH'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic up, input logic melt,
                           input logic [31:0] dx, input logic [31:0] dy);
    drain();
    write_reg(cvvi_pkg::REG_UPSTREAM_MODE, {31'b0, up});
    write_reg(cvvi_pkg::REG_BASAL_MELT, {31'b0, melt});
    write_reg(cvvi_pkg::REG_INV_DX, dx);
    write_reg(cvvi_pkg::REG_INV_DY, dy);
  endtask

  initial begin
    res.ready = 1'b0;
    @(posedge clk);
    forever begin : sink_loop
      int unsigned stall;
      res.ready <= 1'b1;
      repeat (accept_len()) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("column_vertical_velocity_integrator_unit_tb failed");
    $finish;
  end

  initial begin : stimulus
    cvvi_pkg::level_t it;
    int unsigned      sent;
    int unsigned      col_len;
    int unsigned      phase_left;
    bit               no_gaps;
    logic [4:0]       col_icy;

    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    lvl.valid      = 1'b0;
    lvl.u_west     = '0;
    lvl.u_center   = '0;
    lvl.u_east     = '0;
    lvl.v_south    = '0;
    lvl.v_center   = '0;
    lvl.v_north    = '0;
    lvl.level_gap  = '0;
    lvl.base_level = 1'b0;
    lvl.icy_flags  = '0;
    lvl.basal_melt = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // level ahead of any base integrates from the reset state
    send_level(make_level(32'h0100_0000, 32'hFF00_0000, 32'h0300_0000, V_MAX, 32'h5,
                          V_MIN, 32'h0001_0000, 1'b0, 5'h1F, 32'h0100_0000), idle_len());

    configure(1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_level(make_level(V_MIN, 32'h0, V_MAX, V_MAX, 32'h0, V_MIN,
                          32'h0, 1'b1, 5'h1F, V_MIN), idle_len());
    send_level(make_level(V_MIN, 32'h0, V_MAX, V_MAX, 32'h0, V_MIN,
                          32'hFFFF_FFFF, 1'b0, 5'h1F, 32'h0), idle_len());
    send_level(make_level(V_MAX, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN,
                          32'h0, 1'b0, 5'h00, V_MAX), idle_len());
    // margins, sides kept: none, east only, west and north, south only
    send_level(make_level(32'h0100_0000, 32'h0, 32'h0200_0000, 32'h0300_0000, 32'h0,
                          32'h0, 32'h0, 1'b1, 5'h01, 32'h0012_3456), idle_len());
    send_level(make_level(32'h0100_0000, 32'h0, 32'h0200_0000, 32'h0300_0000, 32'h0,
                          32'hFF00_0000, 32'h0001_8000, 1'b0, 5'h01, 32'h0), idle_len());
    send_level(make_level(32'hFF00_0000, 32'h0080_0000, 32'h0200_0000, 32'h0, 32'h0,
                          32'h0, 32'h0, 1'b1, 5'h03, 32'hFFF0_0000), idle_len());
    send_level(make_level(32'hFF00_0000, 32'h0080_0000, 32'h0200_0000, 32'h0, 32'h0,
                          32'h0100_0000, 32'h0002_0000, 1'b0, 5'h03, 32'h0), idle_len());
    send_level(make_level(32'h0200_0000, 32'hFF80_0000, 32'h0, 32'h0100_0000,
                          32'h0300_0000, 32'hFE00_0000, 32'h0, 1'b1, 5'h12, 32'h0),
               idle_len());
    send_level(make_level(32'h0200_0000, 32'hFF80_0000, 32'h0, 32'h0100_0000,
                          32'h0300_0000, 32'hFE00_0000, 32'h0000_8000, 1'b0, 5'h12,
                          32'h0), idle_len());
    send_level(make_level(32'h0200_0000, 32'h0, 32'h0, 32'h0400_0000, 32'hFC00_0000,
                          32'h0, 32'h0, 1'b1, 5'h0E, 32'h0), idle_len());
    send_level(make_level(32'h0200_0000, 32'h0, 32'h0, 32'h0400_0000, 32'hFC00_0000,
                          32'h0, 32'h0001_0000, 1'b0, 5'h1E, 32'h0), idle_len());

    // upstream picks: west only, east only, both, south only, north only
    configure(1'b1, 1'b0, 32'h0100_0000, 32'h8000_0000);
    send_level(make_level(32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
                          32'h0, 1'b1, 5'h1F, 32'h0), idle_len());
    send_level(make_level(32'h0300_0000, 32'h0100_0000, 32'h0, 32'h0, 32'h0200_0000,
                          32'hFF00_0000, 32'h0001_0000, 1'b0, 5'h1F, 32'h0), idle_len());
    send_level(make_level(32'h5, 32'hFFFF_FFFB, 32'h5, V_MAX, V_MAX, V_MAX,
                          32'h0, 1'b1, 5'h1F, 32'h0), idle_len());
    send_level(make_level(V_MIN, V_MIN, V_MIN, V_MAX, V_MIN, V_MAX,
                          32'h0, 1'b1, 5'h1F, 32'h0), idle_len());
    send_level(make_level(V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX,
                          32'hFFFF_FFFF, 1'b0, 5'h1F, 32'h0), idle_len());

    configure(1'b1, 1'b1, 32'h0, 32'h0);
    send_level(make_level(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                          32'h0, 1'b1, 5'h00, V_MAX), idle_len());
    send_level(make_level(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                          32'h0, 1'b1, 5'h00, 32'h0), idle_len());
    send_level(make_level(V_MAX, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN,
                          32'hFFFF_FFFF, 1'b0, 5'h00, V_MIN), idle_len());

    sent       = 0;
    phase_left = 0;
    while (sent < RANDOM_LEVELS) begin
      if (phase_left == 0) begin
        configure(1'($urandom), 1'($urandom), rand_scale(), rand_scale());
        phase_left = $urandom_range(100, 250);
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        col_len = $urandom_range(1, 10);
        col_icy = rand_icy();
        for (int k = 0; k < col_len; k++) begin
          it = make_level(rand_vel(), rand_vel(), rand_vel(), rand_vel(), rand_vel(),
                          rand_vel(), rand_gap(), k == 0,
                          (k == 0) ? col_icy : 5'($urandom), rand_vel());
          send_level(it, no_gaps ? 0 : idle_len());
        end
      end else begin
        col_len = 1;
        it = make_level(rand_vel(), rand_vel(), rand_vel(), rand_vel(), rand_vel(),
                        rand_vel(), rand_gap(), 1'($urandom), 5'($urandom), rand_vel());
        send_level(it, no_gaps ? 0 : idle_len());
      end
      sent       += col_len;
      phase_left  = (col_len >= phase_left) ? 0 : phase_left - col_len;
    end

    lvl.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("column_vertical_velocity_integrator_unit_tb passed");
    end else begin
      $display("column_vertical_velocity_integrator_unit_tb failed");
    end
    $finish;
  end

endmodule
